### rtl/m4inv_pkg.sv
// shared widths, codes and helper functions of the 4x4 adjugate matrix inverter
`default_nettype none

package m4inv_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;

   localparam int ELEM_W    = 32;
   localparam int THR_W     = 31;
   localparam int IN_W      = 4 * ELEM_W;
   localparam int OUT_W     = 5 * ELEM_W;
   localparam int USER_W    = 2;
   localparam int CSR_IDX_W = 1;

   localparam int ROW_W   = 4 * WORD_BITS;
   localparam int MUL_W   = WORD_BITS + 1;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int COF_W   = 3 * WORD_BITS + 4;
   localparam int DET_W   = 4 * WORD_BITS + 4;
   localparam int LIM_W   = THR_W + 3 * FRAC_BITS;
   localparam int CMP_W   = (DET_W > LIM_W) ? DET_W : LIM_W;
   localparam int WIDE_W  = CMP_W + 1;
   localparam int NUM_W   = COF_W + 2 * FRAC_BITS;
   localparam int DSH_W   = DET_W + WORD_BITS;
   localparam int REM_W   = ((NUM_W > DSH_W) ? NUM_W : DSH_W) + 1;
   localparam int QV_W    = WORD_BITS + 1;
   localparam int KCNT_W  = $clog2(WORD_BITS + 1);

   localparam logic [2:0] TERM_LAST  = 3'd5;
   localparam logic [2:0] PHASE_LAST = 3'd6;

   localparam int USER_SINGULAR  = 0;
   localparam int USER_SATURATED = 1;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [ROW_W-1:0]            row_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_POLICY    = 1'b1
   } csr_index_type;

   // index of a 3x3 minor row or column in the full matrix
   function automatic logic [1:0] minor_map(input logic [1:0] k, input logic [1:0] skip);
      return (k < skip) ? k : 2'(k + 2'd1);
   endfunction

   // minor column used by minor row k in permutation term t
   function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] k);
      logic [5:0] cols;
      case (t)
         3'd0:    cols = {2'd2, 2'd1, 2'd0};
         3'd1:    cols = {2'd0, 2'd2, 2'd1};
         3'd2:    cols = {2'd1, 2'd0, 2'd2};
         3'd3:    cols = {2'd1, 2'd2, 2'd0};
         3'd4:    cols = {2'd2, 2'd0, 2'd1};
         3'd5:    cols = {2'd0, 2'd1, 2'd2};
         default: cols = 6'd0;
      endcase
      case (k)
         2'd0:    return cols[1:0];
         2'd1:    return cols[3:2];
         default: return cols[5:4];
      endcase
   endfunction

   function automatic logic perm_neg(input logic [2:0] t);
      return t > 3'd2;
   endfunction

   function automatic word_type elem_sel(input row_type row, input logic [1:0] col);
      case (col)
         2'd0:    return row[0 +: WORD_BITS];
         2'd1:    return row[WORD_BITS +: WORD_BITS];
         2'd2:    return row[2*WORD_BITS +: WORD_BITS];
         default: return row[3*WORD_BITS +: WORD_BITS];
      endcase
   endfunction

endpackage

`default_nettype wire

### rtl/m4inv_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module m4inv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/matrix4_inverse_adjugate_top.sv
// 4x4 matrix inverter by adjugate over a shared multiplier and a bit-serial divider
`default_nettype none

// Rows of a signed fixed-point 4x4 matrix arrive one per transfer. The fourth row starts the
// computation and the block is not ready until all four result rows are transferred: the
// sixteen cofactors go through one shared multiplier, three multiplies per permutation term,
// and the determinant and its check follow. A nonsingular matrix then runs each element
// through a restoring divider, one quotient bit a cycle; a singular one reads each row back
// from the matrix store and sends it, or zeros, as the policy bit selects. Each result row
// waits in its output register for rsp_tready.
module matrix4_inverse_adjugate_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // elem_x, elem_y, elem_z, elem_w
   input  wire logic [m4inv_pkg::IN_W-1:0]        req_tdata,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // out_x, out_y, out_z, out_w, det_value
   output      logic [m4inv_pkg::OUT_W-1:0]       rsp_tdata,
   // singular, saturated
   output      logic [m4inv_pkg::USER_W-1:0]      rsp_tuser,
   output      logic                              rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [m4inv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [m4inv_pkg::THR_W-1:0]       csr_wdata
);

   localparam int W = m4inv_pkg::WORD_BITS;
   localparam int F = m4inv_pkg::FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_COF, ST_DET, ST_MAG, ST_RND, ST_DFETCH, ST_DLOAD, ST_DINIT,
      ST_DSTEP, ST_DFIN, ST_SFETCH, ST_SLOAD, ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]  row_cnt_ff, row_cnt_in;
   logic [3:0]  cof_idx_ff, cof_idx_in;
   logic [2:0]  term_ff, term_in;
   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  col_ff, col_in;
   logic [1:0]  orow_ff, orow_in;
   logic [m4inv_pkg::KCNT_W-1:0] kcnt_ff, kcnt_in;
   logic [m4inv_pkg::THR_W-1:0]  thr_ff, thr_in;
   logic        policy_ff, policy_in;
   logic        add_en_ff, add_en_in;
   logic        add_neg_ff, add_neg_in;
   logic [1:0]  add_sh_ff, add_sh_in;

   logic signed [m4inv_pkg::PROD_W-1:0] mul_ff, mul_in;
   logic signed [m4inv_pkg::MUL_W-1:0]  mul_a, mul_b;
   m4inv_pkg::word_type                 e_ff, e_in;
   logic [2*W-1:0]                      p_ff, p_in;
   logic [m4inv_pkg::DET_W-1:0]         acc_ff, acc_in, acc_sum, sh_val, sh_base;
   logic [m4inv_pkg::COF_W-1:0]         cof_ff, cof_in, cmag;
   logic [m4inv_pkg::DET_W-1:0]         det_ff, det_in, dmag_ff, dmag_in;
   logic                                dneg_ff, dneg_in;
   logic                                sing_ff, sing_in;
   logic                                dclip_ff, dclip_in;
   m4inv_pkg::word_type                 detv_ff, detv_in;
   logic [m4inv_pkg::REM_W-1:0]         rem_ff, rem_in, dsh_ff, dsh_in;
   logic [W-1:0]                        q_ff, q_in;
   logic                                qneg_ff, qneg_in;
   logic                                ovf_ff, ovf_in;
   logic                                rclip_ff, rclip_in;
   m4inv_pkg::word_type                 row_ff [4];
   m4inv_pkg::word_type                 row_in [4];

   logic [1:0] r_sel, c_sel, mcol;
   logic       term_neg;
   logic [m4inv_pkg::CMP_W-1:0]  lim_cmp;
   logic [m4inv_pkg::WIDE_W-1:0] drnd, dlim, dsat;
   logic                         rem_ge, rup, qclip;
   logic [m4inv_pkg::QV_W-1:0]   qv, qlim, qsat;

   logic                       mst_we;
   logic [1:0]                 mst_raddr;
   m4inv_pkg::row_type         mst_wdata, mst_rdata;
   logic                       cof_we;
   logic [3:0]                 cof_raddr;
   logic [m4inv_pkg::COF_W-1:0] cof_wdata, cof_rdata;
   logic                       req_xfer;

   m4inv_ram #(.WIDTH(m4inv_pkg::ROW_W), .DEPTH(4)) u_mstore (
      .clock   (clock),
      .wr_en   (mst_we),
      .wr_addr (row_cnt_ff),
      .wr_data (mst_wdata),
      .rd_addr (mst_raddr),
      .rd_data (mst_rdata)
   );

   m4inv_ram #(.WIDTH(m4inv_pkg::COF_W), .DEPTH(16)) u_cofstore (
      .clock   (clock),
      .wr_en   (cof_we),
      .wr_addr (cof_idx_ff),
      .wr_data (cof_wdata),
      .rd_addr (cof_raddr),
      .rd_data (cof_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign mst_we     = req_xfer;
   assign mst_wdata  = {req_tdata[3*m4inv_pkg::ELEM_W +: W], req_tdata[2*m4inv_pkg::ELEM_W +: W],
                        req_tdata[m4inv_pkg::ELEM_W +: W], req_tdata[0 +: W]};

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tlast  = (orow_ff == 2'd3);
   assign rsp_tdata  = {m4inv_pkg::ELEM_W'(detv_ff), m4inv_pkg::ELEM_W'(row_ff[3]),
                        m4inv_pkg::ELEM_W'(row_ff[2]), m4inv_pkg::ELEM_W'(row_ff[1]),
                        m4inv_pkg::ELEM_W'(row_ff[0])};
   assign rsp_tuser[m4inv_pkg::USER_SINGULAR]  = sing_ff;
   assign rsp_tuser[m4inv_pkg::USER_SATURATED] = rclip_ff;

   // cofactor term addressing
   assign r_sel    = cof_idx_ff[3:2];
   assign c_sel    = cof_idx_ff[1:0];
   assign term_neg = m4inv_pkg::perm_neg(term_ff) ^ r_sel[0] ^ c_sel[0];

   always_comb begin
      sh_base = m4inv_pkg::DET_W'(mul_ff);
      case (add_sh_ff)
         2'd0:    sh_val = sh_base;
         2'd1:    sh_val = sh_base << W;
         2'd2:    sh_val = sh_base << (2 * W);
         default: sh_val = sh_base << (3 * W);
      endcase
      if (!add_en_ff) begin
         acc_sum = acc_ff;
      end else if (add_neg_ff) begin
         acc_sum = acc_ff - sh_val;
      end else begin
         acc_sum = acc_ff + sh_val;
      end
   end

   assign mul_in = mul_a * mul_b;

   // determinant check and rounding
   always_comb begin
      lim_cmp = m4inv_pkg::CMP_W'(thr_ff) << (3 * F);
      drnd    = (m4inv_pkg::WIDE_W'(dmag_ff) + (m4inv_pkg::WIDE_W'(1) << (3 * F - 1))) >> (3 * F);
      dlim    = (m4inv_pkg::WIDE_W'(1) << (W - 1)) - m4inv_pkg::WIDE_W'(!dneg_ff);
      dsat    = (drnd > dlim) ? dlim : drnd;
   end

   // divider step and final rounding
   always_comb begin
      cmag   = cof_ff[m4inv_pkg::COF_W-1] ? m4inv_pkg::COF_W'(~cof_ff + 1'b1) : cof_ff;
      rem_ge = rem_ff >= dsh_ff;
      rup    = (rem_ff << 1) >= m4inv_pkg::REM_W'(dmag_ff);
      qv     = {1'b0, q_ff} + m4inv_pkg::QV_W'(rup);
      qlim   = (m4inv_pkg::QV_W'(1) << (W - 1)) - m4inv_pkg::QV_W'(!qneg_ff);
      qclip  = ovf_ff || (qv > qlim);
      qsat   = qclip ? qlim : qv;
   end

   always_comb begin
      state_in   = state_ff;
      row_cnt_in = row_cnt_ff;
      cof_idx_in = cof_idx_ff;
      term_in    = term_ff;
      phase_in   = phase_ff;
      col_in     = col_ff;
      orow_in    = orow_ff;
      kcnt_in    = kcnt_ff;
      thr_in     = thr_ff;
      policy_in  = policy_ff;
      add_en_in  = 1'b0;
      add_neg_in = 1'b0;
      add_sh_in  = 2'd0;
      e_in       = e_ff;
      p_in       = p_ff;
      acc_in     = acc_sum;
      cof_in     = cof_ff;
      det_in     = det_ff;
      dmag_in    = dmag_ff;
      dneg_in    = dneg_ff;
      sing_in    = sing_ff;
      dclip_in   = dclip_ff;
      detv_in    = detv_ff;
      rem_in     = rem_ff;
      dsh_in     = dsh_ff;
      q_in       = q_ff;
      qneg_in    = qneg_ff;
      ovf_in     = ovf_ff;
      rclip_in   = rclip_ff;
      for (int i = 0; i < 4; i++) begin
         row_in[i] = row_ff[i];
      end
      mul_a     = '0;
      mul_b     = '0;
      mst_raddr = 2'd0;
      cof_raddr = 4'd0;
      cof_we    = 1'b0;
      cof_wdata = acc_sum[m4inv_pkg::COF_W-1:0];
      mcol      = 2'd0;

      if (csr_we) begin
         case (m4inv_pkg::csr_index_type'(csr_index))
            m4inv_pkg::CSR_THRESHOLD: thr_in    = csr_wdata;
            m4inv_pkg::CSR_POLICY:    policy_in = csr_wdata[0];
            default:                  thr_in    = thr_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               row_cnt_in = 2'(row_cnt_ff + 2'd1);
               if (row_cnt_ff == 2'd3) begin
                  state_in   = ST_COF;
                  cof_idx_in = 4'd0;
                  term_in    = 3'd0;
                  phase_in   = 3'd0;
                  acc_in     = '0;
               end
            end
         end
         ST_COF: begin
            phase_in = 3'(phase_ff + 3'd1);
            case (phase_ff)
               3'd0: begin
                  mst_raddr = m4inv_pkg::minor_map(2'd0, r_sel);
               end
               3'd1: begin
                  mcol      = m4inv_pkg::minor_map(m4inv_pkg::perm_col(term_ff, 2'd0), c_sel);
                  e_in      = m4inv_pkg::elem_sel(mst_rdata, mcol);
                  mst_raddr = m4inv_pkg::minor_map(2'd1, r_sel);
               end
               3'd2: begin
                  mcol      = m4inv_pkg::minor_map(m4inv_pkg::perm_col(term_ff, 2'd1), c_sel);
                  mul_a     = m4inv_pkg::MUL_W'(e_ff);
                  mul_b     = m4inv_pkg::MUL_W'(m4inv_pkg::elem_sel(mst_rdata, mcol));
                  mst_raddr = m4inv_pkg::minor_map(2'd2, r_sel);
               end
               3'd3: begin
                  mcol = m4inv_pkg::minor_map(m4inv_pkg::perm_col(term_ff, 2'd2), c_sel);
                  p_in = mul_ff[2*W-1:0];
                  e_in = m4inv_pkg::elem_sel(mst_rdata, mcol);
               end
               3'd4: begin
                  mul_a      = {1'b0, p_ff[W-1:0]};
                  mul_b      = m4inv_pkg::MUL_W'(e_ff);
                  add_en_in  = 1'b1;
                  add_neg_in = term_neg;
                  add_sh_in  = 2'd0;
               end
               3'd5: begin
                  mul_a      = m4inv_pkg::MUL_W'($signed(p_ff[2*W-1:W]));
                  mul_b      = m4inv_pkg::MUL_W'(e_ff);
                  add_en_in  = 1'b1;
                  add_neg_in = term_neg;
                  add_sh_in  = 2'd1;
               end
               default: begin
                  phase_in = 3'd0;
                  if (term_ff == m4inv_pkg::TERM_LAST) begin
                     cof_we  = 1'b1;
                     acc_in  = '0;
                     term_in = 3'd0;
                     if (cof_idx_ff == 4'd15) begin
                        state_in = ST_DET;
                        col_in   = 2'd0;
                     end else begin
                        cof_idx_in = 4'(cof_idx_ff + 4'd1);
                     end
                  end else begin
                     term_in = 3'(term_ff + 3'd1);
                  end
               end
            endcase
         end
         ST_DET: begin
            phase_in = 3'(phase_ff + 3'd1);
            case (phase_ff)
               3'd0: begin
                  cof_raddr = {2'd0, col_ff};
                  mst_raddr = 2'd0;
               end
               3'd1: begin
                  cof_in = cof_rdata;
                  e_in   = m4inv_pkg::elem_sel(mst_rdata, col_ff);
               end
               3'd2, 3'd3, 3'd4: begin
                  mul_a     = {1'b0, cof_ff[(phase_ff - 3'd2) * W +: W]};
                  mul_b     = m4inv_pkg::MUL_W'(e_ff);
                  add_en_in = 1'b1;
                  add_sh_in = 2'(phase_ff - 3'd2);
               end
               3'd5: begin
                  mul_a     = m4inv_pkg::MUL_W'($signed(cof_ff[m4inv_pkg::COF_W-1:3*W]));
                  mul_b     = m4inv_pkg::MUL_W'(e_ff);
                  add_en_in = 1'b1;
                  add_sh_in = 2'd3;
               end
               default: begin
                  phase_in = 3'd0;
                  if (col_ff == 2'd3) begin
                     det_in   = acc_sum;
                     state_in = ST_MAG;
                  end else begin
                     col_in = 2'(col_ff + 2'd1);
                  end
               end
            endcase
         end
         ST_MAG: begin
            dneg_in  = det_ff[m4inv_pkg::DET_W-1];
            dmag_in  = det_ff[m4inv_pkg::DET_W-1] ? m4inv_pkg::DET_W'(~det_ff + 1'b1) : det_ff;
            state_in = ST_RND;
         end
         ST_RND: begin
            sing_in  = m4inv_pkg::CMP_W'(dmag_ff) <= lim_cmp;
            dclip_in = drnd > dlim;
            rclip_in = drnd > dlim;
            detv_in  = W'(dneg_ff ? m4inv_pkg::WIDE_W'(~dsat + 1'b1) : dsat);
            orow_in  = 2'd0;
            col_in   = 2'd0;
            state_in = (m4inv_pkg::CMP_W'(dmag_ff) <= lim_cmp) ? ST_SFETCH : ST_DFETCH;
         end
         ST_DFETCH: begin
            cof_raddr = {col_ff, orow_ff};
            state_in  = ST_DLOAD;
         end
         ST_DLOAD: begin
            cof_in   = cof_rdata;
            state_in = ST_DINIT;
         end
         ST_DINIT: begin
            rem_in   = m4inv_pkg::REM_W'(cmag) << (2 * F);
            dsh_in   = m4inv_pkg::REM_W'(dmag_ff) << W;
            qneg_in  = cof_ff[m4inv_pkg::COF_W-1] ^ dneg_ff;
            q_in     = '0;
            ovf_in   = 1'b0;
            kcnt_in  = m4inv_pkg::KCNT_W'(W);
            state_in = ST_DSTEP;
         end
         ST_DSTEP: begin
            if (rem_ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            if (kcnt_ff == m4inv_pkg::KCNT_W'(W)) begin
               ovf_in = rem_ge;
            end else begin
               q_in = {q_ff[W-2:0], rem_ge};
            end
            dsh_in = dsh_ff >> 1;
            if (kcnt_ff == '0) begin
               state_in = ST_DFIN;
            end else begin
               kcnt_in = m4inv_pkg::KCNT_W'(kcnt_ff - 1'b1);
            end
         end
         ST_DFIN: begin
            row_in[col_ff] = W'(qneg_ff ? m4inv_pkg::QV_W'(~qsat + 1'b1) : qsat);
            rclip_in       = rclip_ff | qclip;
            if (col_ff == 2'd3) begin
               state_in = ST_OUT;
            end else begin
               col_in   = 2'(col_ff + 2'd1);
               state_in = ST_DFETCH;
            end
         end
         ST_SFETCH: begin
            mst_raddr = orow_ff;
            state_in  = ST_SLOAD;
         end
         ST_SLOAD: begin
            for (int i = 0; i < 4; i++) begin
               row_in[i] = policy_ff ? m4inv_pkg::elem_sel(mst_rdata, 2'(i)) : '0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               if (orow_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end else begin
                  orow_in  = 2'(orow_ff + 2'd1);
                  col_in   = 2'd0;
                  rclip_in = dclip_ff;
                  state_in = sing_ff ? ST_SFETCH : ST_DFETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff   <= mul_in;
      e_ff     <= e_in;
      p_ff     <= p_in;
      acc_ff   <= acc_in;
      cof_ff   <= cof_in;
      det_ff   <= det_in;
      dmag_ff  <= dmag_in;
      dneg_ff  <= dneg_in;
      sing_ff  <= sing_in;
      dclip_ff <= dclip_in;
      detv_ff  <= detv_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      q_ff     <= q_in;
      qneg_ff  <= qneg_in;
      ovf_ff   <= ovf_in;
      rclip_ff <= rclip_in;
      kcnt_ff  <= kcnt_in;
      for (int i = 0; i < 4; i++) begin
         row_ff[i] <= row_in[i];
      end
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_cnt_ff <= 2'd0;
         cof_idx_ff <= 4'd0;
         term_ff    <= 3'd0;
         phase_ff   <= 3'd0;
         col_ff     <= 2'd0;
         orow_ff    <= 2'd0;
         thr_ff     <= '0;
         policy_ff  <= 1'b0;
         add_en_ff  <= 1'b0;
         add_neg_ff <= 1'b0;
         add_sh_ff  <= 2'd0;
      end else begin
         state_ff   <= state_in;
         row_cnt_ff <= row_cnt_in;
         cof_idx_ff <= cof_idx_in;
         term_ff    <= term_in;
         phase_ff   <= phase_in;
         col_ff     <= col_in;
         orow_ff    <= orow_in;
         thr_ff     <= thr_in;
         policy_ff  <= policy_in;
         add_en_ff  <= add_en_in;
         add_neg_ff <= add_neg_in;
         add_sh_ff  <= add_sh_in;
      end
   end

endmodule

`default_nettype wire
